// ----- src/pfdc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfdc_pkg
// Shared types, codes and SHA-256 constants for the frame digest checker.
// ----------------------------------------------------------------------------
package pfdc_pkg;

  localparam int unsigned EXP_BYTES_W = 24;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned BLOCK_W     = 512;

  localparam logic [3:0] NIB_MASK  = 4'hF;
  localparam logic [3:0] CODE_HOLE = 4'd4;
  localparam logic [3:0] CODE_TOP  = 4'd7;

  localparam logic [CFG_IDX_W-1:0] REG_EXP_BYTES = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIGEST_0  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIGEST_1  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIGEST_2  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIGEST_3  = 3'd4;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_CODE   = 2'd1;
  localparam logic [1:0] ST_BAD_LENGTH = 2'd2;
  localparam logic [1:0] ST_BAD_DIGEST = 2'd3;

  localparam logic [0:7][31:0] INIT_H = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef enum logic [1:0] {
    F_IN,
    F_P80,
    F_ZERO,
    F_LEN
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_RUN,
    B_ADD,
    B_CHK,
    B_OUT
  } back_state_t;

  // One complete 64-byte block handed from intake to the hash engine
  typedef struct packed {
    logic [BLOCK_W-1:0] blk;
    logic               last;
    logic [1:0]         st_pre;
  } blk_entry_t;

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k;
    unique case (t)
      6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491; 6'd2:  k = 32'hb5c0fbcf;
      6'd3:  k = 32'he9b5dba5; 6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5; 6'd8:  k = 32'hd807aa98;
      6'd9:  k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

endpackage

// ----- src/pfdc_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfdc_front
// Byte intake: checks pixel codes, counts bytes, packs 64-byte blocks and
// appends SHA-256 padding after the final byte.
// ----------------------------------------------------------------------------
module pfdc_front #(
  parameter int unsigned COUNT_WIDTH = 24
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  logic [7:0]                       pixel_byte,
  input  logic                             final_byte,
  input  logic [pfdc_pkg::EXP_BYTES_W-1:0] expected_bytes,
  output logic                             q_push,
  output pfdc_pkg::blk_entry_t             q_entry,
  input  logic                             q_full
);
  import pfdc_pkg::*;

  front_state_t              state, state_next;
  logic [5:0]                fill;
  logic [BLOCK_W-1:0]        blk;
  logic [COUNT_WIDTH-1:0]    cnt;
  logic [COUNT_WIDTH-1:0]    cnt_next;
  logic                      ovf, ovf_next;
  logic                      cerr, cerr_next;
  logic [63:0]               len_bits;
  logic [2:0]                len_idx;
  logic [1:0]                st_pre;
  logic                      in_acc;
  logic                      byte_do;
  logic [7:0]                byte_val;
  logic                      len_bad;
  logic [3:0]                nib_hi, nib_lo;
  logic                      code_ok;

  assign nib_hi  = pixel_byte[7:4] & NIB_MASK;
  assign nib_lo  = pixel_byte[3:0] & NIB_MASK;
  assign code_ok = (nib_hi < CODE_TOP) && (nib_hi != CODE_HOLE) &&
                   (nib_lo < CODE_TOP) && (nib_lo != CODE_HOLE);

  assign full   = (state != F_IN) || q_full;
  assign in_acc = push && !full;

  always_comb begin
    cerr_next = cerr || !code_ok;
    if (cnt == {COUNT_WIDTH{1'b1}}) begin
      cnt_next = cnt;
      ovf_next = 1'b1;
    end else begin
      cnt_next = cnt + 1'b1;
      ovf_next = ovf;
    end
    len_bad = ovf_next || (64'(cnt_next) != 64'(expected_bytes));
  end

  always_comb begin
    state_next = state;
    byte_do    = 1'b0;
    byte_val   = 8'h00;
    unique case (state)
      F_IN: begin
        byte_do  = in_acc;
        byte_val = pixel_byte;
        if (in_acc && final_byte) state_next = F_P80;
      end
      F_P80: begin
        byte_do  = !q_full;
        byte_val = 8'h80;
        if (!q_full) state_next = F_ZERO;
      end
      F_ZERO: begin
        if (fill == 6'd56) begin
          state_next = F_LEN;
        end else begin
          byte_do = !q_full;
        end
      end
      F_LEN: begin
        byte_do  = !q_full;
        byte_val = len_bits[63:56];
        if (!q_full && len_idx == 3'd7) state_next = F_IN;
      end
      default: state_next = F_IN;
    endcase
  end

  // Block leaves when its 64th byte goes in
  assign q_push         = byte_do && (fill == 6'd63);
  assign q_entry.blk    = {blk[BLOCK_W-9:0], byte_val};
  assign q_entry.last   = (state == F_LEN);
  assign q_entry.st_pre = st_pre;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= F_IN;
      fill    <= '0;
      cnt     <= '0;
      ovf     <= 1'b0;
      cerr    <= 1'b0;
      len_idx <= '0;
    end else begin
      state <= state_next;
      if (byte_do) fill <= fill + 6'd1;
      if (in_acc) begin
        if (final_byte) begin
          cnt  <= '0;
          ovf  <= 1'b0;
          cerr <= 1'b0;
        end else begin
          cnt  <= cnt_next;
          ovf  <= ovf_next;
          cerr <= cerr_next;
        end
      end
      if (state == F_LEN && !q_full) len_idx <= len_idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_do) blk <= {blk[BLOCK_W-9:0], byte_val};
    if (in_acc && final_byte) begin
      len_bits <= 64'({cnt_next, 3'b000});
      priority if (cerr_next) st_pre <= ST_BAD_CODE;
      else if (len_bad)       st_pre <= ST_BAD_LENGTH;
      else                    st_pre <= ST_OK;
    end else if (state == F_LEN && !q_full) begin
      len_bits <= {len_bits[55:0], 8'h00};
    end
  end

endmodule

// ----- src/pfdc_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfdc_queue
// Two-entry block queue between intake and hash engine.
// ----------------------------------------------------------------------------
module pfdc_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr,
  input  pfdc_pkg::blk_entry_t wr_data,
  output logic                 q_full,
  input  logic                 rd,
  output pfdc_pkg::blk_entry_t rd_data,
  output logic                 q_empty,
  output logic [1:0]           q_count
);
  import pfdc_pkg::*;

  blk_entry_t mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign q_full  = (count == 2'd2);
  assign q_empty = (count == 2'd0);
  assign rd_data = mem[rd_ptr];
  assign q_count = count;

  always_ff @(posedge clk) begin
    if (wr) mem[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (wr) wr_ptr <= ~wr_ptr;
      if (rd) rd_ptr <= ~rd_ptr;
      unique case ({wr, rd})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- src/pfdc_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfdc_back
// SHA-256 engine: one round per cycle over queued blocks, then digest check
// and four result words.
// ----------------------------------------------------------------------------
module pfdc_back (
  input  logic                 clk,
  input  logic                 rst,
  input  pfdc_pkg::blk_entry_t q_entry,
  input  logic                 q_empty,
  output logic                 q_pop,
  input  logic [255:0]         expected_digest,
  output logic                 empty,
  input  logic                 pop,
  output logic [63:0]          digest_word,
  output logic [1:0]           word_index,
  output logic [1:0]           check_status,
  output logic                 last_word
);
  import pfdc_pkg::*;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  back_state_t     state, state_next;
  logic [0:7][31:0] hv;
  logic [0:7][31:0] vr;
  logic [31:0]     win [16];
  logic [5:0]      rnd;
  logic            last;
  logic [1:0]      st_pre;
  logic [1:0]      status;
  logic [1:0]      idx;
  logic [31:0]     s0, s1, w_new, e1, ch, t1, a0, mj;
  logic            out_take;

  assign out_take = (state == B_OUT) && pop;

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = B_RUN;
        end
      end
      B_RUN:  if (rnd == 6'd63) state_next = B_ADD;
      B_ADD:  state_next = last ? B_CHK : B_IDLE;
      B_CHK:  state_next = B_OUT;
      B_OUT:  if (pop && idx == 2'd3) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    s0    = rotr(win[1], 7) ^ rotr(win[1], 18) ^ (win[1] >> 3);
    s1    = rotr(win[14], 17) ^ rotr(win[14], 19) ^ (win[14] >> 10);
    w_new = win[0] + s0 + win[9] + s1;
    e1    = rotr(vr[4], 6) ^ rotr(vr[4], 11) ^ rotr(vr[4], 25);
    ch    = (vr[4] & vr[5]) ^ (~vr[4] & vr[6]);
    t1    = vr[7] + e1 + ch + round_k(rnd) + win[0];
    a0    = rotr(vr[0], 2) ^ rotr(vr[0], 13) ^ rotr(vr[0], 22);
    mj    = (vr[0] & vr[1]) ^ (vr[0] & vr[2]) ^ (vr[1] & vr[2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      hv    <= INIT_H;
      rnd   <= '0;
      idx   <= '0;
    end else begin
      state <= state_next;
      if (q_pop) rnd <= '0;
      else if (state == B_RUN) rnd <= rnd + 6'd1;
      if (state == B_ADD) begin
        for (int i = 0; i < 8; i++) hv[i] <= hv[i] + vr[i];
      end
      if (state == B_CHK) idx <= '0;
      if (out_take) begin
        idx <= idx + 2'd1;
        // run done: restart chaining value for the next frame
        if (idx == 2'd3) hv <= INIT_H;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      for (int i = 0; i < 16; i++) win[i] <= q_entry.blk[BLOCK_W-1-32*i -: 32];
      vr     <= hv;
      last   <= q_entry.last;
      st_pre <= q_entry.st_pre;
    end else if (state == B_RUN) begin
      for (int i = 0; i < 15; i++) win[i] <= win[i+1];
      win[15] <= w_new;
      vr      <= {t1 + a0 + mj, vr[0], vr[1], vr[2], vr[3] + t1, vr[4], vr[5], vr[6]};
    end
    if (state == B_CHK) begin
      priority if (st_pre != ST_OK)       status <= st_pre;
      else if (hv != expected_digest)     status <= ST_BAD_DIGEST;
      else                                status <= ST_OK;
    end
  end

  assign empty        = (state != B_OUT);
  assign digest_word  = {hv[{idx, 1'b0}], hv[{idx, 1'b1}]};
  assign word_index   = idx;
  assign check_status = status;
  assign last_word    = (idx == 2'd3);

endmodule

// ----- src/packed_frame_digest_check_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_frame_digest_check_unit
// Pixel-code check, byte count check and SHA-256 digest check of a frame.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle while the intake is not padding and the block
// queue has room; each 64-byte block then passes through the SHA-256 engine as
// a load, 64 rounds and an add, so the single-round compression loop limits the
// rate of a long frame. After the final byte the intake pads while the queue has
// room, then the engine finishes one or two blocks and shows the four digest
// words; a new frame may be pushed meanwhile. Status priority is bad pixel code,
// then length mismatch, then digest mismatch.
module packed_frame_digest_check_unit #(
  parameter int unsigned COUNT_WIDTH = 24
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic [7:0]                      pixel_byte,
  input  logic                            final_byte,
  output logic                            empty,
  input  logic                            pop,
  output logic [63:0]                     digest_word,
  output logic [1:0]                      word_index,
  output logic [1:0]                      check_status,
  output logic                            last_word,
  input  logic                            cfg_we,
  input  logic [pfdc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pfdc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pfdc_pkg::*;

  logic [EXP_BYTES_W-1:0] expected_bytes;
  logic [255:0]           expected_digest;
  blk_entry_t             f_entry, b_entry;
  logic                   f_push, q_full, q_empty, b_pop;
  logic [1:0]             q_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_bytes  <= EXP_BYTES_W'(192000);
      expected_digest <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_EXP_BYTES: expected_bytes           <= cfg_data[EXP_BYTES_W-1:0];
        REG_DIGEST_0:  expected_digest[255:192] <= cfg_data;
        REG_DIGEST_1:  expected_digest[191:128] <= cfg_data;
        REG_DIGEST_2:  expected_digest[127:64]  <= cfg_data;
        REG_DIGEST_3:  expected_digest[63:0]    <= cfg_data;
        default: ;
      endcase
    end
  end

  pfdc_front #(.COUNT_WIDTH(COUNT_WIDTH)) u_front (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .pixel_byte(pixel_byte), .final_byte(final_byte),
    .expected_bytes(expected_bytes),
    .q_push(f_push), .q_entry(f_entry), .q_full(q_full)
  );

  pfdc_queue u_queue (
    .clk(clk), .rst(rst), .wr(f_push), .wr_data(f_entry), .q_full(q_full),
    .rd(b_pop), .rd_data(b_entry), .q_empty(q_empty), .q_count(q_count)
  );

  pfdc_back u_back (
    .clk(clk), .rst(rst), .q_entry(b_entry), .q_empty(q_empty), .q_pop(b_pop),
    .expected_digest(expected_digest),
    .empty(empty), .pop(pop), .digest_word(digest_word),
    .word_index(word_index), .check_status(check_status), .last_word(last_word)
  );

`ifndef SYNTHESIS
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count != 2'd3) else $error("block queue count out of range");
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !f_push) else $error("block pushed into full queue");
  a_run_end: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && last_word) |=> empty) else $error("results after last word");
  a_word_step: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && !last_word) |=> (!empty && word_index == $past(word_index) + 2'd1))
    else $error("digest word order broken");
`endif

endmodule

// ----- sim/packed_frame_digest_check_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_frame_digest_check_unit_tb
// Drives packed pixel frames through the digest checker and compares every
// digest word and status against a SHA-256 frame model kept in the bench.
// Covers pixel code errors, length errors, digest matches and mismatches
// and padding across block edges.
// ----------------------------------------------------------------------------
module packed_frame_digest_check_unit_tb;
  import pfdc_pkg::*;

  localparam int unsigned CW = 16;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd5;
  localparam int unsigned SETTLE = 300;

  localparam logic [0:7][31:0] SHA_IV = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };
  localparam logic [0:63][31:0] SHA_K = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    logic [255:0] h;
    logic [511:0] blk;
    logic [5:0]   fill;
  } sha_ctx_t;

  typedef struct packed {
    logic [7:0] b;
    logic       fin;
    logic       hold;   // wait until every digest word is out before sending
  } frame_byte_t;

  typedef struct packed {
    logic [63:0] dw;
    logic [1:0]  idx;
    logic [1:0]  st;
    logic        lw;
  } digest_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic [7:0] pixel_byte = '0;
  logic final_byte = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic [63:0] digest_word;
  logic [1:0] word_index;
  logic [1:0] check_status;
  logic last_word;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  packed_frame_digest_check_unit #(.COUNT_WIDTH(CW)) uut (.*);

  frame_byte_t  byte_q[$];
  digest_word_t digest_q[$];
  logic [7:0]   frame_buf[$];
  logic [7:0]   ref_buf[$];
  int           idle_pct = 0;
  int           stall_pct = 0;
  int           errors = 0;

  // frame model state and its register copies
  sha_ctx_t       run_ctx;
  logic [CW-1:0]  run_cnt;
  logic           run_ovf, run_bad;
  logic [23:0]    want_len;
  logic [255:0]   want_digest;

  initial forever #1 clk = ~clk;

  initial begin
    #20_000_000;
    $display("packed_frame_digest_check_unit_tb: FAIL");
    $finish;
  end

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [255:0] sha_compress(input logic [255:0] h, input logic [511:0] blk);
    logic [31:0] w [0:63];
    logic [31:0] v [0:7];
    logic [31:0] t1, t2;
    logic [255:0] r;
    int i;
    for (i = 0; i < 16; i++) w[i] = blk[511 - 32 * i -: 32];
    for (i = 16; i < 64; i++) begin
      w[i] = w[i-16] + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
           + w[i-7] + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
    end
    for (i = 0; i < 8; i++) v[i] = h[255 - 32 * i -: 32];
    for (i = 0; i < 64; i++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[i] + w[i];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (i = 0; i < 8; i++) r[255 - 32 * i -: 32] = h[255 - 32 * i -: 32] + v[i];
    return r;
  endfunction

  function automatic sha_ctx_t sha_start();
    sha_ctx_t c;
    c.h = SHA_IV;
    c.blk = '0;
    c.fill = '0;
    return c;
  endfunction

  function automatic sha_ctx_t sha_absorb(input sha_ctx_t c, input logic [7:0] b);
    c.blk[511 - 8 * c.fill -: 8] = b;
    c.fill = c.fill + 6'd1;
    if (c.fill == 6'd0) c.h = sha_compress(c.h, c.blk);
    return c;
  endfunction

  function automatic logic [255:0] sha_close(input sha_ctx_t c, input logic [63:0] bits);
    int i;
    c = sha_absorb(c, 8'h80);
    while (c.fill != 6'd56) c = sha_absorb(c, 8'h00);
    for (i = 0; i < 8; i++) c = sha_absorb(c, bits[63 - 8 * i -: 8]);
    return c.h;
  endfunction

  function automatic logic nibble_ok(input logic [3:0] n);
    return n < CODE_TOP && n != CODE_HOLE;
  endfunction

  function automatic logic [3:0] legal_nibble();
    logic [3:0] v;
    v = 4'($urandom_range(0, 5));
    return (v > 4'd3) ? v + 4'd1 : v;
  endfunction

  task automatic frame_restart();
    run_ctx = sha_start();
    run_cnt = '0;
    run_ovf = 1'b0;
    run_bad = 1'b0;
  endtask

  // absorb one accepted byte; on the final byte queue the four digest words
  task automatic absorb_pixel_byte(input logic [7:0] b, input logic fin);
    logic [255:0] dig;
    logic [1:0]   st;
    int i;
    if (!nibble_ok(b[7:4]) || !nibble_ok(b[3:0])) run_bad = 1'b1;
    if (run_cnt == '1) run_ovf = 1'b1;
    else run_cnt = run_cnt + 1'b1;
    run_ctx = sha_absorb(run_ctx, b);
    if (fin) begin
      dig = sha_close(run_ctx, 64'(run_cnt) << 3);
      if (run_bad) st = ST_BAD_CODE;
      else if (run_ovf || 24'(run_cnt) != want_len) st = ST_BAD_LENGTH;
      else if (dig != want_digest) st = ST_BAD_DIGEST;
      else st = ST_OK;
      for (i = 0; i < 4; i++)
        digest_q.push_back('{dw: dig[255 - 64 * i -: 64], idx: 2'(i), st: st, lw: (i == 3)});
      frame_restart();
    end
  endtask

  // digest of frame_buf as the block computes it, counter saturation included
  function automatic logic [255:0] frame_buf_digest();
    sha_ctx_t c;
    logic [CW-1:0] n;
    int i;
    c = sha_start();
    n = '0;
    for (i = 0; i < frame_buf.size(); i++) begin
      c = sha_absorb(c, frame_buf[i]);
      if (n != '1) n = n + 1'b1;
    end
    return sha_close(c, 64'(n) << 3);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_EXP_BYTES: want_len = data[23:0];
      REG_DIGEST_0:  want_digest[255:192] = data;
      REG_DIGEST_1:  want_digest[191:128] = data;
      REG_DIGEST_2:  want_digest[127:64] = data;
      REG_DIGEST_3:  want_digest[63:0] = data;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_digest(input logic [255:0] d);
    write_reg(REG_DIGEST_0, d[255:192]);
    write_reg(REG_DIGEST_1, d[191:128]);
    write_reg(REG_DIGEST_2, d[127:64]);
    write_reg(REG_DIGEST_3, d[63:0]);
  endtask

  task automatic queue_frame(input logic hold);
    int i;
    for (i = 0; i < frame_buf.size(); i++)
      byte_q.push_back('{b: frame_buf[i], fin: (i == frame_buf.size() - 1), hold: hold && i == 0});
  endtask

  task automatic build_frame(input int len, input int bad_pct);
    int i;
    frame_buf.delete();
    for (i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < bad_pct) frame_buf.push_back(8'($urandom));
      else frame_buf.push_back({legal_nibble(), legal_nibble()});
    end
  endtask

  task automatic send_bytes(input logic [7:0] a, input logic [7:0] b, input int n);
    frame_buf.delete();
    frame_buf.push_back(a);
    if (n > 1) frame_buf.push_back(b);
    queue_frame(1'b0);
  endtask

  task automatic drain();
    do @(posedge clk); while (byte_q.size() != 0 || digest_q.size() != 0 || push);
    repeat (SETTLE) @(posedge clk);
  endtask

  // sender: hold the word while full, else advance to the next pending byte
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else if (!push || !full) begin
      if (push) absorb_pixel_byte(pixel_byte, final_byte);
      if (byte_q.size() != 0 && $urandom_range(0, 99) >= idle_pct &&
          !(byte_q[0].hold && digest_q.size() != 0)) begin
        push <= 1'b1;
        pixel_byte <= byte_q[0].b;
        final_byte <= byte_q[0].fin;
        void'(byte_q.pop_front());
      end else begin
        push <= 1'b0;
      end
    end
  end

  // receiver: check each popped word against the oldest expected one
  always @(posedge clk) begin
    digest_word_t e;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (digest_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected digest word %h", digest_word);
        end else begin
          e = digest_q.pop_front();
          if (digest_word !== e.dw || word_index !== e.idx || check_status !== e.st ||
              last_word !== e.lw) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp %h idx %0d st %0d last %0d, got %h idx %0d st %0d last %0d",
                       e.dw, e.idx, e.st, e.lw, digest_word, word_index, check_status, last_word);
          end
        end
      end
      pop <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  initial begin
    logic [255:0] d;
    int ph, f, r, len;
    want_len = 24'd192000;
    want_digest = '0;
    frame_restart();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset values: every frame is a length error or a code error
    send_bytes(8'h00, 8'h00, 1);
    send_bytes(8'hFF, 8'h00, 1);
    send_bytes(8'h47, 8'h00, 1);
    send_bytes(8'h12, 8'h35, 2);
    send_bytes(8'h60, 8'h03, 2);
    send_bytes(8'h74, 8'h11, 2);
    drain();

    // matching frame, then a single flipped digest bit
    frame_buf.delete();
    frame_buf.push_back(8'h65);
    d = frame_buf_digest();
    write_reg(REG_EXP_BYTES, 64'd1);
    write_digest(d);
    write_reg(REG_SPARE, '1);
    send_bytes(8'h65, 8'h00, 1);
    send_bytes(8'h65, 8'h00, 1);
    drain();
    write_reg(REG_DIGEST_3, {d[63:1], ~d[0]});
    send_bytes(8'h65, 8'h00, 1);
    send_bytes(8'h56, 8'h00, 1);
    drain();

    // extreme register values
    write_reg(REG_EXP_BYTES, 64'hFF_FFFF);
    write_digest('1);
    send_bytes(8'h00, 8'h66, 2);
    drain();

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 88; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 88; end
        default: begin idle_pct = 34; stall_pct = 34; end
      endcase
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(55, 66) : $urandom_range(1, 12);
      build_frame(len, 0);
      ref_buf = frame_buf;
      d = frame_buf_digest();
      if ($urandom_range(0, 3) == 0) d[$urandom_range(0, 255)] ^= 1'b1;
      write_reg(REG_EXP_BYTES, 64'(len));
      write_digest(d);
      for (f = 0; f < 3; f++) begin
        r = $urandom_range(0, 99);
        if (r < 35) begin
          frame_buf = ref_buf;
        end else if (r < 55) begin
          build_frame(len, 0);
        end else begin
          build_frame(($urandom_range(0, 9) == 0) ? $urandom_range(55, 70)
                                                   : $urandom_range(1, 12), 10);
        end
        queue_frame(f == 1 || $urandom_range(0, 4) == 0);
      end
      drain();
    end

    if (errors == 0 && digest_q.size() == 0) begin
      $display("packed_frame_digest_check_unit_tb: PASS");
    end else begin
      $display("packed_frame_digest_check_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
